### src/encv_pkg.sv
package encv_pkg;

    // Timer and field widths.
    localparam int TIMER_BITS = 16;
    localparam int CAP_W      = 16;
    localparam int FACTOR_W   = 26;
    localparam int LIMIT_W    = 8;
    localparam int COUNT_W    = LIMIT_W;
    localparam int VEL_W      = 27;

    // Elapsed time spans the overflow count on top of the timer bits.
    localparam int DELTA_W    = TIMER_BITS + COUNT_W;

    // One quotient bit is produced per divider step.
    localparam int STEP_W     = $clog2(FACTOR_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FACTOR_W;

    // Register reset values.
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(25000000);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(10);

    // Request kinds and channels.
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;
    localparam logic CHAN_A       = 1'b0;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_FACTOR  = 1'b0,
        REG_TIMEOUT_LIMIT = 1'b1
    } encv_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } encv_state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } encv_div_status_t;

endpackage

### src/encv_meas_if.sv
interface encv_meas_if;
    import encv_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic             channel;
    logic [CAP_W-1:0] capture_value;
    logic             level_a;
    logic             level_b;

    modport source (
        output valid, kind, channel, capture_value, level_a, level_b,
        input  ready
    );

    modport sink (
        input  valid, kind, channel, capture_value, level_a, level_b,
        output ready
    );

endinterface

### src/encv_speed_if.sv
interface encv_speed_if;
    import encv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity;

    modport source (
        output valid, velocity,
        input  ready
    );

    modport sink (
        input  valid, velocity,
        output ready
    );

endinterface

### src/encoder_period_velocity.sv
// Channel    Dir   Handshake        Payload
// meas       in    valid / ready    kind, channel, capture_value, level_a, level_b
// speed      out   valid / ready    velocity
// write_*    in    write_en         write_index, write_data
//
// A timer tick is taken in ST_IDLE and goes through ST_WRITE into the output
// register once that register is free. A capture first runs 26 radix-2 steps
// of the shared divider, is signed and stored, then goes through ST_WRITE;
// a zero period skips the divider and goes straight to ST_WRITE, as a tick does.
// A new request is taken only while the sequencer is idle; the output
// register lets the next request in while the last result is still waiting.
// Reset clears the period state and loads the register defaults.
module encoder_period_velocity (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_en,
    input  logic [encv_pkg::CFG_IDX_W-1:0]   write_index,
    input  logic [encv_pkg::CFG_DATA_W-1:0]  write_data,
    encv_meas_if.sink                        meas,
    encv_speed_if.source                     speed
);
    import encv_pkg::*;

    encv_state_t             state_reg, state_next;
    logic [FACTOR_W-1:0]     factor_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [TIMER_BITS-1:0]   last_cap_reg, last_cap_next;
    logic [VEL_W-1:0]        last_vel_reg, last_vel_next;
    logic [TIMER_BITS-1:0]   cap_reg;
    logic                    pos_reg;
    logic [VEL_W-1:0]        res_reg, res_next;
    logic                    out_valid_reg;
    logic [VEL_W-1:0]        out_vel_reg;

    logic                    accept;
    logic                    div_start;
    logic                    out_load;
    logic [TIMER_BITS-1:0]   cap;
    logic [COUNT_W-1:0]      cnt_inc;
    logic                    tick_zero;
    logic [DELTA_W-1:0]      diff;
    logic [DELTA_W-1:0]      delta;
    logic                    delta_zero;
    logic                    levels_eq;
    logic                    positive;
    logic [FACTOR_W-1:0]     quotient;
    logic [VEL_W-1:0]        mag;
    logic [VEL_W-1:0]        signed_vel;
    encv_div_status_t        div_status;

    // Shared divider: speed factor over the measured period.
    encv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (factor_reg),
        .divisor  (delta),
        .status   (div_status),
        .quotient (quotient)
    );

    // Tick path: saturating overflow count against the timeout limit.
    assign cap       = TIMER_BITS'(meas.capture_value);
    assign cnt_inc   = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign tick_zero = (cnt_inc >= limit_reg);

    // Capture path: elapsed time, wrapped within one timer period when no
    // overflow has been seen since the previous capture.
    assign diff       = {count_reg, cap} - {{COUNT_W{1'b0}}, last_cap_reg};
    assign delta      = (count_reg == '0) ? {{COUNT_W{1'b0}}, diff[TIMER_BITS-1:0]} : diff;
    assign delta_zero = (delta == '0);

    // Direction from the pin levels and the capturing channel.
    assign levels_eq = (meas.level_a == meas.level_b);
    assign positive  = (meas.channel == CHAN_A) ? levels_eq : !levels_eq;

    // Signed result once the divider finishes.
    assign mag        = {1'b0, quotient};
    assign signed_vel = pos_reg ? mag : -mag;

    // Sequencer outputs.
    always_comb
    begin
        meas.ready = (state_reg == ST_IDLE);
        accept     = (state_reg == ST_IDLE) && meas.valid;
        div_start  = accept && (meas.kind == KIND_CAPTURE) && !delta_zero;
        out_load   = (state_reg == ST_WRITE) && (!out_valid_reg || speed.ready);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas.valid)
                begin
                    if (meas.kind == KIND_TICK || delta_zero)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Period state and pending result.
    always_comb
    begin
        count_next    = count_reg;
        last_cap_next = last_cap_reg;
        last_vel_next = last_vel_reg;
        res_next      = res_reg;
        if (accept && meas.kind == KIND_TICK)
        begin
            if (tick_zero)
            begin
                count_next    = limit_reg;
                last_vel_next = '0;
                res_next      = '0;
            end
            else
            begin
                count_next = cnt_inc;
                res_next   = last_vel_reg;
            end
        end
        else if (accept && delta_zero)
        begin
            res_next = last_vel_reg;
        end
        else if (state_reg == ST_DIV && div_status.done)
        begin
            count_next    = '0;
            last_cap_next = cap_reg;
            last_vel_next = signed_vel;
            res_next      = signed_vel;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            factor_reg    <= FACTOR_RESET;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            last_cap_reg  <= '0;
            last_vel_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_cap_reg <= last_cap_next;
            last_vel_reg <= last_vel_next;
            if (write_en)
            begin
                unique case (write_index)
                    REG_SPEED_FACTOR:  factor_reg <= write_data;
                    REG_TIMEOUT_LIMIT: limit_reg  <= write_data[LIMIT_W-1:0];
                    default:           factor_reg <= factor_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (speed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (div_start)
        begin
            cap_reg <= cap;
            pos_reg <= positive;
        end
        if (out_load)
        begin
            out_vel_reg <= res_reg;
        end
    end

    assign speed.valid    = out_valid_reg;
    assign speed.velocity = out_vel_reg;

endmodule

### src/encv_div.sv
module encv_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [encv_pkg::FACTOR_W-1:0]  dividend,
    input  logic [encv_pkg::DELTA_W-1:0]   divisor,
    output encv_pkg::encv_div_status_t     status,
    output logic [encv_pkg::FACTOR_W-1:0]  quotient
);
    import encv_pkg::*;

    logic [FACTOR_W-1:0] num_reg, num_next;
    logic [DELTA_W-1:0]  den_reg;
    logic [DELTA_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DELTA_W:0]    trial;
    logic [DELTA_W:0]    diff;
    logic                fits;

    // Restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {rem_reg, num_reg[FACTOR_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Step sequencing; quotient bits shift in where dividend bits leave.
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            cnt_next  = STEP_W'(FACTOR_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[FACTOR_W-2:0], fits};
            rem_next = fits ? diff[DELTA_W-1:0] : trial[DELTA_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = num_reg;

endmodule

### src/encv_chk.sv
module encv_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           meas_valid,
    input  logic                           meas_ready,
    input  logic                           meas_kind,
    input  logic                           speed_valid,
    input  logic                           speed_ready,
    input  logic [encv_pkg::VEL_W-1:0]     speed_velocity
);
    import encv_pkg::*;

    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        speed_valid && !speed_ready |=> speed_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        speed_valid && !speed_ready |=> $stable(speed_velocity))
        else $error("stalled result changed");

    // Requests are worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready |=> !meas_ready)
        else $error("request taken while the previous one is in progress");

    // A tick accepted with a free output slot reaches the output through ST_WRITE without a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready && meas_kind == KIND_TICK
        && (!speed_valid || speed_ready) |-> ##2 speed_valid)
        else $error("tick result missing");

endmodule

bind encoder_period_velocity encv_chk u_encv_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .meas_valid     (meas.valid),
    .meas_ready     (meas.ready),
    .meas_kind      (meas.kind),
    .speed_valid    (speed.valid),
    .speed_ready    (speed.ready),
    .speed_velocity (speed.velocity)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import encv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_MAX     = 10;
    localparam int SETTLE_CYCLES  = 64;

    typedef struct packed {
        logic             kind;
        logic             channel;
        logic [CAP_W-1:0] capture_value;
        logic             level_a;
        logic             level_b;
    } meas_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  write_en;
    logic [CFG_IDX_W-1:0]  write_index;
    logic [CFG_DATA_W-1:0] write_data;

    encv_meas_if  meas_ch ();
    encv_speed_if speed_ch ();

    encoder_period_velocity DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .meas        (meas_ch),
        .speed       (speed_ch)
    );

    // Predicted register contents and period state.
    logic [FACTOR_W-1:0]     factor_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [CAP_W-1:0]        model_capture;
    logic signed [VEL_W-1:0] held_velocity;
    logic [COUNT_W-1:0]      tick_count;

    // Requests waiting to be offered and velocities still to arrive.
    meas_req_t               meas_pending[$];
    logic signed [VEL_W-1:0] speed_expected[$];

    // Capture value of the last capture request queued, for near captures.
    logic [CAP_W-1:0] gen_capture;

    int  in_count;
    int  in_seen;
    int  in_gap;
    bit  in_took;
    bit  calm_in;
    int  out_count;
    int  out_seen;
    int  out_gap;
    bit  out_took;
    bit  calm_out;
    bit  hold_rx;
    int  idle_cycles;
    int  errors;

    meas_req_t               seen_req;
    logic signed [VEL_W-1:0] want_velocity;

    // Expected velocity for one accepted request; advances the predicted state.
    function automatic logic signed [VEL_W-1:0] predict_velocity(meas_req_t req);
        longint delta;
        longint mag;
        longint cap;
        bit     positive;
        cap = longint'(req.capture_value) & ((longint'(1) << TIMER_BITS) - 1);
        if (req.kind == KIND_TICK)
        begin
            if (tick_count != {COUNT_W{1'b1}})
                tick_count = tick_count + 1'b1;
            if (tick_count >= limit_reg)
            begin
                tick_count    = limit_reg;
                held_velocity = '0;
                return '0;
            end
            return held_velocity;
        end
        delta = (longint'(tick_count) << TIMER_BITS) + cap - longint'(model_capture);
        // A timer wrap with no overflow tick in between.
        if (tick_count == '0 && delta < 0)
            delta = delta + (longint'(1) << TIMER_BITS);
        // No time has passed: keep everything as it was.
        if (delta <= 0)
            return held_velocity;
        positive = (req.channel == CHAN_A) ? (req.level_a == req.level_b)
                                           : (req.level_a != req.level_b);
        mag           = longint'(factor_reg) / delta;
        held_velocity = positive ? VEL_W'(mag) : VEL_W'(-mag);
        model_capture = CAP_W'(cap);
        tick_count    = '0;
        return held_velocity;
    endfunction

    // Idle length between handshakes: mostly none or short, now and then long.
    function automatic int draw_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    task automatic push_tick();
        meas_req_t r;
        r               = '0;
        r.kind          = KIND_TICK;
        r.channel       = $urandom_range(0, 1);
        r.capture_value = CAP_W'($urandom);
        r.level_a       = $urandom_range(0, 1);
        r.level_b       = $urandom_range(0, 1);
        meas_pending.push_back(r);
    endtask

    task automatic push_capture(logic chan, logic [CAP_W-1:0] cap, logic la, logic lb);
        meas_req_t r;
        r               = '0;
        r.kind          = KIND_CAPTURE;
        r.channel       = chan;
        r.capture_value = cap;
        r.level_a       = la;
        r.level_b       = lb;
        meas_pending.push_back(r);
        gen_capture = cap;
    endtask

    task automatic push_random_capture(logic [CAP_W-1:0] cap);
        push_capture($urandom_range(0, 1), cap, $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // Random traffic: captures near and far, repeats, ticks and tick bursts
    // that run the count up to the timeout.
    task automatic add_random(int n);
        int added;
        int r;
        int burst;
        added = 0;
        while (added < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                push_tick();
                added++;
            end
            else if (r < 28)
            begin
                burst = int'(limit_reg) - 1 + $urandom_range(0, 3);
                if (burst > 40)
                    burst = $urandom_range(1, 40);
                if (burst < 1)
                    burst = 1;
                repeat (burst) push_tick();
                added += burst;
            end
            else
            begin
                if (r < 55)
                    push_random_capture(gen_capture + CAP_W'($urandom_range(1, 64)));
                else if (r < 80)
                    push_random_capture(CAP_W'($urandom));
                else if (r < 88)
                    push_random_capture(gen_capture);
                else
                    push_random_capture(gen_capture + CAP_W'($urandom_range(256, 4095)));
                added++;
            end
        end
    endtask

    task automatic write_reg(encv_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= data;
        @(negedge clk);
        write_en    <= 1'b0;
        write_data  <= CFG_DATA_W'($urandom);
        if (idx == REG_SPEED_FACTOR)
            factor_reg = data[FACTOR_W-1:0];
        else
            limit_reg = data[LIMIT_W-1:0];
    endtask

    // The limit is written with junk above its width, which must be dropped.
    task automatic set_config(logic [FACTOR_W-1:0] factor, logic [LIMIT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] data;
        data                = CFG_DATA_W'($urandom);
        data[LIMIT_W-1:0]   = limit;
        write_reg(REG_SPEED_FACTOR, CFG_DATA_W'(factor));
        write_reg(REG_TIMEOUT_LIMIT, data);
    endtask

    // Wait until every queued request has been answered and the block is idle.
    task automatic drain();
        while (meas_pending.size() != 0 || speed_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Request driver: offers the oldest pending request after a random gap.
    always @(negedge clk)
    begin
        if (!rst_n)
            meas_ch.valid <= 1'b0;
        else
        begin
            in_took = (in_count != in_seen);
            in_seen = in_count;
            if (in_took)
            begin
                in_gap = draw_gap(calm_in);
                if ($urandom_range(0, 49) == 0)
                    calm_in = !calm_in;
            end
            if (meas_ch.valid && !in_took)
                ;
            else if (in_gap > 0)
            begin
                meas_ch.valid <= 1'b0;
                in_gap--;
            end
            else if (meas_pending.size() > 0)
            begin
                meas_ch.valid         <= 1'b1;
                meas_ch.kind          <= meas_pending[0].kind;
                meas_ch.channel       <= meas_pending[0].channel;
                meas_ch.capture_value <= meas_pending[0].capture_value;
                meas_ch.level_a       <= meas_pending[0].level_a;
                meas_ch.level_b       <= meas_pending[0].level_b;
            end
            else
                meas_ch.valid <= 1'b0;
        end
    end

    // Accepted requests are predicted from what was on the bus.
    always @(posedge clk)
    begin
        if (rst_n && meas_ch.valid && meas_ch.ready)
        begin
            seen_req.kind          = meas_ch.kind;
            seen_req.channel       = meas_ch.channel;
            seen_req.capture_value = meas_ch.capture_value;
            seen_req.level_a       = meas_ch.level_a;
            seen_req.level_b       = meas_ch.level_b;
            speed_expected.push_back(predict_velocity(seen_req));
            meas_pending.pop_front();
            in_count++;
        end
    end

    // Result receiver: ready with random gaps, forced low during the hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            speed_ch.ready <= 1'b0;
        else
        begin
            out_took = (out_count != out_seen);
            out_seen = out_count;
            if (out_took)
            begin
                out_gap = draw_gap(calm_out);
                if ($urandom_range(0, 49) == 0)
                    calm_out = !calm_out;
            end
            if (hold_rx)
                speed_ch.ready <= 1'b0;
            else if (out_gap > 0)
            begin
                speed_ch.ready <= 1'b0;
                out_gap--;
            end
            else
                speed_ch.ready <= 1'b1;
        end
    end

    // Each velocity is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && speed_ch.valid && speed_ch.ready)
        begin
            out_count++;
            if (speed_expected.size() == 0)
            begin
                if (errors < REPORT_MAX)
                    $display("unexpected velocity %0d with no request outstanding",
                             speed_ch.velocity);
                errors++;
            end
            else
            begin
                want_velocity = speed_expected.pop_front();
                if (speed_ch.velocity !== want_velocity)
                begin
                    if (errors < REPORT_MAX)
                        $display("velocity mismatch: expected %0d, got %0d",
                                 want_velocity, speed_ch.velocity);
                    errors++;
                end
            end
        end
    end

    // Long receiver hold-off while requests keep coming, so the block backs up.
    initial
    begin
        hold_rx = 1'b0;
        wait (in_count >= 150);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((meas_ch.valid && meas_ch.ready) || (speed_ch.valid && speed_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles", idle_cycles);
                    $display("FAIL encoder_period_velocity");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        rst_n                  = 1'b0;
        write_en               = 1'b0;
        write_index            = REG_SPEED_FACTOR;
        write_data             = '0;
        meas_ch.valid          = 1'b0;
        meas_ch.kind           = KIND_CAPTURE;
        meas_ch.channel        = CHAN_A;
        meas_ch.capture_value  = '0;
        meas_ch.level_a        = 1'b0;
        meas_ch.level_b        = 1'b0;
        speed_ch.ready         = 1'b0;
        factor_reg             = FACTOR_RESET;
        limit_reg              = LIMIT_RESET;
        model_capture          = '0;
        held_velocity          = '0;
        tick_count             = '0;
        gen_capture            = '0;
        in_count               = 0;
        in_seen                = 0;
        in_gap                 = 0;
        calm_in                = 1'b0;
        out_count              = 0;
        out_seen               = 0;
        out_gap                = 0;
        calm_out               = 1'b0;
        idle_cycles            = 0;
        errors                 = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults after reset: zero period, wraps, both channels
        // and all pin levels, then ticks up to and past the timeout.
        push_capture(CHAN_A, 16'h0000, 1'b0, 1'b0);
        push_tick();
        push_capture(CHAN_A, 16'h0000, 1'b1, 1'b1);
        push_capture(CHAN_A, 16'hFFFF, 1'b0, 1'b1);
        push_capture(~CHAN_A, 16'h0000, 1'b1, 1'b0);
        push_capture(~CHAN_A, 16'h0000, 1'b1, 1'b1);
        push_capture(~CHAN_A, 16'h0001, 1'b1, 1'b1);
        push_capture(CHAN_A, 16'h0002, 1'b1, 1'b0);
        push_capture(~CHAN_A, 16'h8000, 1'b0, 1'b0);
        repeat (12) push_tick();
        push_capture(CHAN_A, 16'hFFFF, 1'b1, 1'b0);
        push_capture(~CHAN_A, 16'h7FFF, 1'b0, 1'b1);
        push_capture(CHAN_A, 16'h5555, 1'b0, 1'b0);
        push_capture(~CHAN_A, 16'hAAAA, 1'b1, 1'b1);
        drain();

        // Largest factor with the shortest timeout: full-scale velocities.
        set_config({FACTOR_W{1'b1}}, LIMIT_W'(1));
        push_tick();
        push_capture(CHAN_A, gen_capture + 1'b1, 1'b0, 1'b0);
        push_capture(~CHAN_A, gen_capture + 1'b1, 1'b0, 1'b0);
        push_tick();
        add_random(50);
        drain();

        // Smallest factor with the longest timeout: the count saturates.
        set_config(FACTOR_W'(1), {LIMIT_W{1'b1}});
        repeat (257) push_tick();
        push_capture(CHAN_A, 16'h1234, 1'b1, 1'b1);
        push_capture(CHAN_A, gen_capture + 1'b1, 1'b1, 1'b1);
        add_random(30);
        drain();

        set_config(FACTOR_W'($urandom), LIMIT_W'($urandom_range(2, 20)));
        add_random(90);
        drain();

        set_config(FACTOR_RESET, LIMIT_RESET);
        add_random(90);
        drain();

        set_config(FACTOR_W'($urandom_range(1, (1 << FACTOR_W) - 1)),
                   LIMIT_W'($urandom_range(1, 255)));
        add_random(60);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && speed_expected.size() == 0)
            $display("PASS encoder_period_velocity");
        else
            $display("FAIL encoder_period_velocity");
        $finish;
    end

endmodule

### sim.f
src/encv_pkg.sv
src/encv_meas_if.sv
src/encv_speed_if.sv
src/encv_div.sv
src/encoder_period_velocity.sv
src/encv_chk.sv
tb/tb_top.sv
